### hdl/radial_brush_height_edit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the radial brush height edit block
// Concurrent checks that vanish in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef RADIAL_BRUSH_HEIGHT_EDIT_ASSERT_SVH
`define RADIAL_BRUSH_HEIGHT_EDIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RBH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbh assertion failed");
`define RBH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbh assertion failed");
`else
`define RBH_ASSERT_IMP(lbl, ante, cons)
`define RBH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hdl/rbh_pkg.sv
// ---------------------------------------------------------------------------
// rbh_pkg
// Shared widths, register indexes and stage payload types.
// ---------------------------------------------------------------------------
package rbh_pkg;

  localparam int CELL_SIZE_CM_DEF = 200;
  localparam int COL_W      = 15;
  localparam int HGT_W      = 16;
  localparam int RAD_W      = 22;
  localparam int DLT_W      = 17;
  localparam int N_W        = 2 * RAD_W;
  localparam int ROOT_STEPS = RAD_W;
  localparam int FALL_SHIFT = 10;
  localparam int WGT_W      = FALL_SHIFT + 1;
  localparam int NUM_W      = RAD_W + FALL_SHIFT;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_X  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_Y  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_H    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_H    = 4'd7;

  typedef struct packed {
    logic signed [22:0]      origin_x;
    logic signed [22:0]      origin_y;
    logic signed [23:0]      brush_x;
    logic signed [23:0]      brush_y;
    logic [RAD_W-1:0]        brush_radius;
    logic signed [DLT_W-1:0] brush_delta;
    logic signed [HGT_W-1:0] min_height;
    logic [14:0]             max_height;
  } rbh_cfg_t;

  typedef struct packed {
    logic                    act;
    logic [N_W-1:0]          n;
    logic signed [HGT_W-1:0] cur;
  } rbh_sq_t;

  typedef struct packed {
    logic                    act;
    logic [RAD_W-1:0]        d;
    logic signed [HGT_W-1:0] cur;
  } rbh_rt_t;

  typedef struct packed {
    logic                    act;
    logic [WGT_W-1:0]        wgt;
    logic signed [HGT_W-1:0] cur;
  } rbh_wt_t;

endpackage

### hdl/rbh_geom.sv
// ---------------------------------------------------------------------------
// rbh_geom
// Cell centre, offsets to the brush, squared distance and disc test.
// ---------------------------------------------------------------------------
module rbh_geom #(
  parameter int CELL_SIZE_CM = rbh_pkg::CELL_SIZE_CM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [rbh_pkg::COL_W-1:0]      cell_col,
  input  logic [rbh_pkg::COL_W-1:0]      cell_row,
  input  logic signed [rbh_pkg::HGT_W-1:0] cur_height,
  input  rbh_pkg::rbh_cfg_t              cfg,
  output logic                           out_vld,
  output rbh_pkg::rbh_sq_t               out_sq
);
  localparam int PROD_W = rbh_pkg::COL_W + $clog2(CELL_SIZE_CM + 1);
  localparam int CW     = ((PROD_W + 1 > 24) ? PROD_W + 1 : 24) + 2;
  localparam int SQ_W   = 2 * CW;
  localparam int R2_W   = 2 * rbh_pkg::RAD_W;

  logic [2:0] vld_r;
  logic signed [CW-1:0] cx_r, cy_r, dx_r, dy_r;
  logic [SQ_W-1:0] sqx_r, sqy_r;
  logic signed [rbh_pkg::HGT_W-1:0] cur1_r, cur2_r, cur3_r;
  logic [R2_W-1:0] r2_r;
  logic out_vld_r;
  rbh_pkg::rbh_sq_t out_r;

  logic [PROD_W-1:0] px_nxt, py_nxt;
  logic signed [CW-1:0] cx_nxt, cy_nxt;
  logic signed [SQ_W-1:0] sqx_nxt, sqy_nxt;
  logic [SQ_W:0] d2_nxt;
  rbh_pkg::rbh_sq_t out_nxt;

  always_comb begin
    px_nxt  = PROD_W'(cell_col) * PROD_W'(CELL_SIZE_CM);
    py_nxt  = PROD_W'(cell_row) * PROD_W'(CELL_SIZE_CM);
    cx_nxt  = CW'(cfg.origin_x) + CW'($signed({1'b0, px_nxt})) + CW'(CELL_SIZE_CM / 2);
    cy_nxt  = CW'(cfg.origin_y) + CW'($signed({1'b0, py_nxt})) + CW'(CELL_SIZE_CM / 2);
    sqx_nxt = dx_r * dx_r;
    sqy_nxt = dy_r * dy_r;
    d2_nxt  = (SQ_W + 1)'(sqx_r) + (SQ_W + 1)'(sqy_r);
    out_nxt.act = (cfg.brush_radius != '0) && (cfg.brush_delta != '0) &&
                  (d2_nxt <= (SQ_W + 1)'(r2_r));
    out_nxt.n   = d2_nxt[rbh_pkg::N_W-1:0];
    out_nxt.cur = cur3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[1:0], in_vld};
      out_vld_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= R2_W'(cfg.brush_radius) * R2_W'(cfg.brush_radius);
    if (en) begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      cur1_r <= cur_height;
      dx_r   <= cx_r - CW'(cfg.brush_x);
      dy_r   <= cy_r - CW'(cfg.brush_y);
      cur2_r <= cur1_r;
      sqx_r  <= $unsigned(sqx_nxt);
      sqy_r  <= $unsigned(sqy_nxt);
      cur3_r <= cur2_r;
      out_r  <= out_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign out_sq  = out_r;
endmodule

### hdl/rbh_sqrt.sv
// ---------------------------------------------------------------------------
// rbh_sqrt
// Integer square root, one result bit per pipeline stage.
// ---------------------------------------------------------------------------
`include "radial_brush_height_edit_assert.svh"
module rbh_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  rbh_pkg::rbh_sq_t  in_sq,
  input  logic [rbh_pkg::RAD_W-1:0] radius,
  output logic              out_vld,
  output rbh_pkg::rbh_rt_t  out_rt
);
  localparam int NS = rbh_pkg::ROOT_STEPS;
  localparam int NW = rbh_pkg::N_W;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] act_r;
  logic [NW-1:0] n_r  [NS];
  logic [NW-1:0] rt_r [NS];
  logic signed [rbh_pkg::HGT_W-1:0] cur_r [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  genvar k;
  for (k = 0; k < NS; k++) begin : g_stage
    localparam logic [NW-1:0] BITV = NW'(1) << (NW - 2 - 2 * k);
    logic [NW-1:0] n_i, rt_i, tr;
    logic act_i;
    logic signed [rbh_pkg::HGT_W-1:0] cur_i;
    if (k == 0) begin : g_first
      assign n_i   = in_sq.n;
      assign rt_i  = '0;
      assign act_i = in_sq.act;
      assign cur_i = in_sq.cur;
    end else begin : g_next
      assign n_i   = n_r[k-1];
      assign rt_i  = rt_r[k-1];
      assign act_i = act_r[k-1];
      assign cur_i = cur_r[k-1];
    end
    assign tr = rt_i + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_i >= tr) begin
          n_r[k]  <= n_i - tr;
          rt_r[k] <= (rt_i >> 1) + BITV;
        end else begin
          n_r[k]  <= n_i;
          rt_r[k] <= rt_i >> 1;
        end
        act_r[k] <= act_i;
        cur_r[k] <= cur_i;
      end
    end
  end

  assign out_vld    = vld_r[NS-1];
  assign out_rt.act = act_r[NS-1];
  assign out_rt.d   = rt_r[NS-1][rbh_pkg::RAD_W-1:0];
  assign out_rt.cur = cur_r[NS-1];

  // a cell inside the disc never lies farther out than the radius
  `RBH_ASSERT_IMP(a_root_in_disc, out_vld && out_rt.act,
                  rt_r[NS-1] <= NW'(radius))
endmodule

### hdl/rbh_div.sv
// ---------------------------------------------------------------------------
// rbh_div
// Falloff weight (r-d)*1024/r by restoring division, one bit per stage.
// ---------------------------------------------------------------------------
`include "radial_brush_height_edit_assert.svh"
module rbh_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  rbh_pkg::rbh_rt_t  in_rt,
  input  logic [rbh_pkg::RAD_W-1:0] radius,
  output logic              out_vld,
  output rbh_pkg::rbh_wt_t  out_wt
);
  localparam int NS = rbh_pkg::WGT_W;
  localparam int MW = rbh_pkg::NUM_W;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] act_r;
  logic [MW-1:0] rem_r [NS];
  logic [NS-1:0] q_r   [NS];
  logic signed [rbh_pkg::HGT_W-1:0] cur_r [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_vld};
    end
  end

  genvar s;
  for (s = 0; s < NS; s++) begin : g_stage
    logic [MW-1:0] rem_i, dsh;
    logic [NS-1:0] q_i;
    logic act_i;
    logic signed [rbh_pkg::HGT_W-1:0] cur_i;
    if (s == 0) begin : g_first
      assign rem_i = MW'(in_rt.d <= radius ? radius - in_rt.d : '0) << rbh_pkg::FALL_SHIFT;
      assign q_i   = '0;
      assign act_i = in_rt.act;
      assign cur_i = in_rt.cur;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign q_i   = q_r[s-1];
      assign act_i = act_r[s-1];
      assign cur_i = cur_r[s-1];
    end
    assign dsh = MW'(radius) << (NS - 1 - s);
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= dsh) begin
          rem_r[s] <= rem_i - dsh;
          q_r[s]   <= {q_i[NS-2:0], 1'b1};
        end else begin
          rem_r[s] <= rem_i;
          q_r[s]   <= {q_i[NS-2:0], 1'b0};
        end
        act_r[s] <= act_i;
        cur_r[s] <= cur_i;
      end
    end
  end

  assign out_vld    = vld_r[NS-1];
  assign out_wt.act = act_r[NS-1];
  assign out_wt.wgt = q_r[NS-1];
  assign out_wt.cur = cur_r[NS-1];

  // weight never exceeds full scale inside the disc
  `RBH_ASSERT_IMP(a_wgt_range, out_vld && out_wt.act,
                  q_r[NS-1] <= NS'(1 << rbh_pkg::FALL_SHIFT))
endmodule

### hdl/rbh_apply.sv
// ---------------------------------------------------------------------------
// rbh_apply
// Scale delta by weight, truncate toward zero, add and clamp.
// ---------------------------------------------------------------------------
`include "radial_brush_height_edit_assert.svh"
module rbh_apply (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  rbh_pkg::rbh_wt_t  in_wt,
  input  rbh_pkg::rbh_cfg_t cfg,
  output logic              out_vld,
  output logic signed [rbh_pkg::HGT_W-1:0] new_height,
  output logic              height_moved
);
  localparam int PW = rbh_pkg::DLT_W + rbh_pkg::WGT_W + 1;
  localparam int OW = rbh_pkg::DLT_W + 1;

  logic vld1_r, vld2_r, act1_r, moved_r;
  logic signed [PW-1:0] prod_r;
  logic signed [rbh_pkg::HGT_W-1:0] cur1_r, new_r;

  logic signed [PW-1:0] prod_nxt, rnd_nxt;
  logic signed [OW-1:0] off_nxt, sum_nxt, lo_nxt, hi_nxt;
  logic signed [rbh_pkg::HGT_W-1:0] new_nxt;

  always_comb begin
    prod_nxt = PW'(cfg.brush_delta) * $signed(PW'(in_wt.wgt));
    // bias negatives so the shift truncates toward zero
    rnd_nxt  = prod_r[PW-1] ? prod_r + PW'((1 << rbh_pkg::FALL_SHIFT) - 1) : prod_r;
    off_nxt  = OW'(rnd_nxt >>> rbh_pkg::FALL_SHIFT);
    sum_nxt  = OW'(cur1_r) + off_nxt;
    lo_nxt   = OW'(cfg.min_height);
    hi_nxt   = OW'($signed({1'b0, cfg.max_height}));
    new_nxt  = cur1_r;
    if (act1_r && off_nxt != '0) begin
      priority if (sum_nxt < lo_nxt) new_nxt = cfg.min_height;
      else if (sum_nxt > hi_nxt)     new_nxt = $signed({1'b0, cfg.max_height});
      else                           new_nxt = sum_nxt[rbh_pkg::HGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      act1_r  <= in_wt.act;
      cur1_r  <= in_wt.cur;
      new_r   <= new_nxt;
      moved_r <= new_nxt != cur1_r;
    end
  end

  assign out_vld      = vld2_r;
  assign new_height   = new_r;
  assign height_moved = moved_r;

  // a cell outside the disc leaves the stage unchanged
  `RBH_ASSERT_IMP(a_idle_no_move, en && vld1_r && !act1_r, new_nxt == cur1_r)
endmodule

### hdl/radial_brush_height_edit.sv
// Stages in order: geometry, root, weight and apply, the apply stage including
// the output register; every stage advances only when the output is not stalled.
// Throughput: one cell per cycle; the whole pipeline holds while a result beat waits.
// Reset (rst_n, synchronous, active low) clears all valid bits and loads the
// register defaults; there is no clearing pass.
// ---------------------------------------------------------------------------
// radial_brush_height_edit
// Linear falloff circular brush applied to one heightfield cell per beat.
// ---------------------------------------------------------------------------
`include "radial_brush_height_edit_assert.svh"
module radial_brush_height_edit #(
  parameter int CELL_SIZE_CM = rbh_pkg::CELL_SIZE_CM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // cell_col[14:0], cell_row[29:15], cur_height[45:30]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // new_height[15:0]
  output logic [0:0]  out_tuser,  // height_moved[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [rbh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbh_pkg::CFG_DATA_W-1:0] cfg_data
);
  rbh_pkg::rbh_cfg_t cfg_r;
  logic en;
  logic g_vld, s_vld, d_vld, a_vld, moved;
  rbh_pkg::rbh_sq_t sq;
  rbh_pkg::rbh_rt_t rt;
  rbh_pkg::rbh_wt_t wt;
  logic signed [rbh_pkg::HGT_W-1:0] new_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.brush_x      <= '0;
      cfg_r.brush_y      <= '0;
      cfg_r.brush_radius <= '0;
      cfg_r.brush_delta  <= '0;
      cfg_r.min_height   <= 16'sh8000;
      cfg_r.max_height   <= 15'h7fff;
    end else if (cfg_valid) begin
      case (cfg_index)
        rbh_pkg::CFG_ORIGIN_X: cfg_r.origin_x     <= cfg_data[22:0];
        rbh_pkg::CFG_ORIGIN_Y: cfg_r.origin_y     <= cfg_data[22:0];
        rbh_pkg::CFG_BRUSH_X:  cfg_r.brush_x      <= cfg_data[23:0];
        rbh_pkg::CFG_BRUSH_Y:  cfg_r.brush_y      <= cfg_data[23:0];
        rbh_pkg::CFG_RADIUS:   cfg_r.brush_radius <= cfg_data[21:0];
        rbh_pkg::CFG_DELTA:    cfg_r.brush_delta  <= cfg_data[16:0];
        rbh_pkg::CFG_MIN_H:    cfg_r.min_height   <= cfg_data[15:0];
        rbh_pkg::CFG_MAX_H:    cfg_r.max_height   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // advance everything unless a result beat is held
  assign en        = !a_vld || out_tready;
  assign in_tready = en;

  rbh_geom #(.CELL_SIZE_CM(CELL_SIZE_CM)) u_geom (
    .clk, .rst_n, .en,
    .in_vld     (in_tvalid && in_tready),
    .cell_col   (in_tdata[14:0]),
    .cell_row   (in_tdata[29:15]),
    .cur_height (in_tdata[45:30]),
    .cfg        (cfg_r),
    .out_vld    (g_vld),
    .out_sq     (sq)
  );

  rbh_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_vld (g_vld), .in_sq (sq), .radius (cfg_r.brush_radius),
    .out_vld (s_vld), .out_rt (rt)
  );

  rbh_div u_div (
    .clk, .rst_n, .en,
    .in_vld (s_vld), .in_rt (rt), .radius (cfg_r.brush_radius),
    .out_vld (d_vld), .out_wt (wt)
  );

  rbh_apply u_apply (
    .clk, .rst_n, .en,
    .in_vld (d_vld), .in_wt (wt), .cfg (cfg_r),
    .out_vld (a_vld), .new_height (new_h), .height_moved (moved)
  );

  assign out_tvalid = a_vld;
  assign out_tdata  = new_h;
  assign out_tuser  = moved;

  `RBH_ASSERT_IMP(a_stall_blocks_input, out_tvalid && !out_tready, !in_tready)
  `RBH_ASSERT_NXT(a_held_result_stays, out_tvalid && !out_tready, out_tvalid)
endmodule
